/* src/fcull_pkg.sv */
// Shared types and constants for the six-plane frustum culling test.
// No dependencies; used by fcull_plane_eval and frustum_cull_test_core.
package fcull_pkg;

    localparam int NUM_PLANES   = 6;
    localparam int NUM_CORNERS  = 8;
    localparam int COORD_FRAC   = 8;
    localparam int SLOT_BITS    = 16;
    localparam int PLANE_BITS   = 64;
    localparam int CFG_IDX_BITS = 3;
    localparam int ACTION_W     = 2;
    localparam int VERDICT_W    = 2;
    localparam int M_TDATA_W    = 8;

    // Primitive kinds carried in tuser
    localparam logic [ACTION_W-1:0] ACT_BOX    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SPHERE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POINT  = 2'd2;

    // Result codes
    localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_INTERSECTS = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_INSIDE     = 2'd2;

    // Per-plane outcome handed from a plane evaluator to the verdict stage
    typedef struct packed {
        logic [NUM_CORNERS-1:0] corner_pos;  // corner distance > 0
        logic                   below_neg_r; // corner 0 distance < -radius
        logic                   below_r;     // corner 0 distance < radius
    } plane_flags_t;

endpackage

/* src/fcull_plane_eval.sv */
// One plane of the culling pipeline: products, pair sums, corner compares.
// Depends on fcull_pkg; instantiated six times by frustum_cull_test_core.
module fcull_plane_eval #(
    parameter int COORD_BITS = 24,
    parameter int COEF_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [COEF_BITS-1:0]           coef_a,
    input  logic signed [COEF_BITS-1:0]           coef_b,
    input  logic signed [COEF_BITS-1:0]           coef_c,
    input  logic signed [COEF_BITS-1:0]           coef_d,
    input  logic signed [COORD_BITS-1:0]          x_lo,
    input  logic signed [COORD_BITS-1:0]          x_hi,
    input  logic signed [COORD_BITS-1:0]          y_lo,
    input  logic signed [COORD_BITS-1:0]          y_hi,
    input  logic signed [COORD_BITS-1:0]          z_lo,
    input  logic signed [COORD_BITS-1:0]          z_hi,
    input  logic signed [COEF_BITS+COORD_BITS+1:0] radius,  // scaled, aligned to stage 3
    output fcull_pkg::plane_flags_t               flags
);

    localparam int PW   = COEF_BITS + COORD_BITS;
    localparam int DW   = PW + 2;
    localparam int DPAD = PW - COEF_BITS - fcull_pkg::COORD_FRAC;

    // Stage 2: one product per coefficient and coordinate choice
    logic signed [PW-1:0] ax_reg [2];
    logic signed [PW-1:0] by_reg [2];
    logic signed [PW-1:0] cz_reg [2];
    logic signed [PW-1:0] dk_reg;
    logic signed [PW-1:0] dk_next;

    assign dk_next = {{DPAD{coef_d[COEF_BITS-1]}}, coef_d, {fcull_pkg::COORD_FRAC{1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg[0] <= coef_a * x_lo;
            ax_reg[1] <= coef_a * x_hi;
            by_reg[0] <= coef_b * y_lo;
            by_reg[1] <= coef_b * y_hi;
            cz_reg[0] <= coef_c * z_lo;
            cz_reg[1] <= coef_c * z_hi;
            dk_reg    <= dk_next;
        end
    end

    // Stage 3: x+y pairs (index = {y_sel, x_sel}) and z+d pairs
    logic signed [PW:0] xy_reg [4];
    logic signed [PW:0] zd_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                xy_reg[i] <= (PW+1)'(ax_reg[i%2]) + (PW+1)'(by_reg[i/2]);
            end
            for (int i = 0; i < 2; i++) begin
                zd_reg[i] <= (PW+1)'(cz_reg[i]) + (PW+1)'(dk_reg);
            end
        end
    end

    // Stage 4: corner distances and sign / radius compares
    logic signed [DW-1:0]    corner_d [fcull_pkg::NUM_CORNERS];
    fcull_pkg::plane_flags_t flags_next;
    fcull_pkg::plane_flags_t flags_reg;

    always_comb begin
        for (int c = 0; c < fcull_pkg::NUM_CORNERS; c++) begin
            corner_d[c] = DW'(xy_reg[c%4]) + DW'(zd_reg[c/4]);
            flags_next.corner_pos[c] = (corner_d[c] > 0);
        end
        flags_next.below_neg_r = (corner_d[0] < -radius);
        flags_next.below_r     = (corner_d[0] < radius);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

/* src/frustum_cull_test_core.sv */
// Six-plane view frustum culling test: top level with plane registers,
// input staging, valid pipeline and verdict stage. Depends on fcull_pkg, fcull_plane_eval.
// Registers from an input transfer to m_tvalid: input, product, pair sum, corner compare,
// verdict. Throughput: one item per cycle while the output is not stalled.
// m_tready low while m_tvalid is high freezes every stage at once; s_tready = !m_tvalid || m_tready.
// aresetn (synchronous, active low) clears the valid pipeline and all six planes to zero.
module frustum_cull_test_core #(
    parameter int COORD_BITS = 24,
    parameter int COEF_BITS  = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // Configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [fcull_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [fcull_pkg::PLANE_BITS-1:0]         cfg_data,
    // Input stream
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // tdata, low bit up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
    // box_max_z, pos_x, pos_y, pos_z, radius, zero pad to bytes
    input  logic [((10*COORD_BITS-1+7)/8)*8-1:0]     s_tdata,
    // tuser: action
    input  logic [fcull_pkg::ACTION_W-1:0]           s_tuser,
    // Result stream
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // tdata, low bit up: verdict, zero pad
    output logic [fcull_pkg::M_TDATA_W-1:0]          m_tdata
);

    localparam int DW   = COEF_BITS + COORD_BITS + 2;
    localparam int RW   = COORD_BITS - 1;
    localparam int RSH  = COEF_BITS - 2;
    localparam int RPAD = DW - RW - RSH;
    localparam int NP   = fcull_pkg::NUM_PLANES;

    // Plane registers
    logic [fcull_pkg::PLANE_BITS-1:0] plane_reg [NP];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NP; p++) begin
                plane_reg[p] <= '0;
            end
        end else if (cfg_valid) begin
            for (int p = 0; p < NP; p++) begin
                if (cfg_index == fcull_pkg::CFG_IDX_BITS'(p)) begin
                    plane_reg[p] <= cfg_data;
                end
            end
        end
    end

    // Global stage enable: everything moves unless the output holds a stalled transfer
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Field unpacking
    logic signed [COORD_BITS-1:0] f_coord [9];
    logic        [RW-1:0]         f_radius;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            f_coord[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
        end
    end
    assign f_radius = s_tdata[9*COORD_BITS +: RW];

    // Stage 1: operand select; sphere and point use the low slots for the position
    logic signed [COORD_BITS-1:0]       lo_reg [3];
    logic signed [COORD_BITS-1:0]       hi_reg [3];
    logic signed [DW-1:0]               rad_s1_reg, rad_s2_reg, rad_s3_reg;
    logic [fcull_pkg::ACTION_W-1:0]     act_reg [4];
    logic                               v_reg [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                lo_reg[i] <= (s_tuser == fcull_pkg::ACT_BOX) ? f_coord[i] : f_coord[6+i];
                hi_reg[i] <= f_coord[3+i];
            end
            rad_s1_reg <= $signed({{RPAD{1'b0}}, f_radius, {RSH{1'b0}}});
            rad_s2_reg <= rad_s1_reg;
            rad_s3_reg <= rad_s2_reg;
            act_reg[0] <= s_tuser;
            for (int i = 1; i < 4; i++) begin
                act_reg[i] <= act_reg[i-1];
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                v_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int i = 1; i < 4; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
            m_tvalid_reg <= v_reg[3];
        end
    end

    // Stages 2 to 4: one evaluator per plane
    fcull_pkg::plane_flags_t flags [NP];

    for (genvar p = 0; p < NP; p++) begin : g_plane
        fcull_plane_eval #(
            .COORD_BITS (COORD_BITS),
            .COEF_BITS  (COEF_BITS)
        ) u_plane (
            .aclk   (aclk),
            .en     (en),
            .coef_a (plane_reg[p][0*fcull_pkg::SLOT_BITS +: COEF_BITS]),
            .coef_b (plane_reg[p][1*fcull_pkg::SLOT_BITS +: COEF_BITS]),
            .coef_c (plane_reg[p][2*fcull_pkg::SLOT_BITS +: COEF_BITS]),
            .coef_d (plane_reg[p][3*fcull_pkg::SLOT_BITS +: COEF_BITS]),
            .x_lo   (lo_reg[0]),
            .x_hi   (hi_reg[0]),
            .y_lo   (lo_reg[1]),
            .y_hi   (hi_reg[1]),
            .z_lo   (lo_reg[2]),
            .z_hi   (hi_reg[2]),
            .radius (rad_s3_reg),
            .flags  (flags[p])
        );
    end

    // Stage 5: combine the six plane outcomes
    logic [fcull_pkg::VERDICT_W-1:0] verdict_next;
    logic [fcull_pkg::VERDICT_W-1:0] verdict_reg;
    logic box_out, box_all_in, sph_out, sph_cross, pt_in;

    always_comb begin
        box_out    = 1'b0;
        box_all_in = 1'b1;
        sph_out    = 1'b0;
        sph_cross  = 1'b0;
        pt_in      = 1'b1;
        for (int p = 0; p < NP; p++) begin
            if (flags[p].corner_pos == '0) box_out = 1'b1;
            if (flags[p].corner_pos != '1) box_all_in = 1'b0;
            if (flags[p].below_neg_r) sph_out = 1'b1;
            if (flags[p].below_r) sph_cross = 1'b1;
            if (!flags[p].corner_pos[0]) pt_in = 1'b0;
        end
        case (act_reg[3])
            fcull_pkg::ACT_BOX: begin
                verdict_next = box_out ? fcull_pkg::VERDICT_OUTSIDE
                             : (box_all_in ? fcull_pkg::VERDICT_INSIDE
                                           : fcull_pkg::VERDICT_INTERSECTS);
            end
            fcull_pkg::ACT_SPHERE: begin
                verdict_next = sph_out ? fcull_pkg::VERDICT_OUTSIDE
                             : (sph_cross ? fcull_pkg::VERDICT_INTERSECTS
                                          : fcull_pkg::VERDICT_INSIDE);
            end
            fcull_pkg::ACT_POINT: begin
                verdict_next = pt_in ? fcull_pkg::VERDICT_INSIDE
                                     : fcull_pkg::VERDICT_OUTSIDE;
            end
            default: begin
                verdict_next = fcull_pkg::VERDICT_OUTSIDE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(fcull_pkg::M_TDATA_W-fcull_pkg::VERDICT_W){1'b0}}, verdict_reg};

    // Checks
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid not cleared by reset");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable({v_reg[0], v_reg[1], v_reg[2], v_reg[3], verdict_reg}))
        else $error("pipeline moved during output stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted transfer lost at stage 1");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (verdict_reg == fcull_pkg::VERDICT_OUTSIDE ||
                      verdict_reg == fcull_pkg::VERDICT_INTERSECTS ||
                      verdict_reg == fcull_pkg::VERDICT_INSIDE))
        else $error("invalid verdict code");

endmodule
